@@ rtl/bdpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared widths, register codes, reset values and types of the button
// debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int BTN_W      = 5;
  localparam int TIME_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_BUTTONS_DEF = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd2;

  localparam logic [DUR_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [DUR_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic             ACTIVE_LOW_RST = 1'b1;

  localparam logic [DUR_W-1:0] DUR_MAX = 16'hFFFF;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef struct packed {
    logic [DUR_W-1:0] debounce_ms;
    logic [DUR_W-1:0] long_press_ms;
    logic             active_low;
  } cfg_t;

  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] last_change;
    logic [TIME_W-1:0] press_start;
    logic              long_sent;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [DUR_W-1:0] duration;
  } event_t;

endpackage

@@ rtl/bdpc_sample_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_sample_if
// Channel of raw button samples with their scan time.
// ----------------------------------------------------------------------------
interface bdpc_sample_if import bdpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BTN_W-1:0]  button_index;
  logic              raw_level;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, button_index, raw_level, time_ms, input ready);
  modport sink   (input valid, button_index, raw_level, time_ms, output ready);
endinterface

@@ rtl/bdpc_event_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_event_if
// Channel of short and long press events.
// ----------------------------------------------------------------------------
interface bdpc_event_if import bdpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] event_button;
  logic             event_kind;
  logic [DUR_W-1:0] duration_ms;

  modport source (output valid, event_button, event_kind, duration_ms, input ready);
  modport sink   (input valid, event_button, event_kind, duration_ms, output ready);
endinterface

@@ rtl/bdpc_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bdpc_cfg_if import bdpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bdpc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_cfg
// Configuration registers: debounce time, long press threshold, polarity.
// ----------------------------------------------------------------------------
module bdpc_cfg import bdpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  bdpc_cfg_if.sink cfg,
  output cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms   <= DEBOUNCE_RST;
      regs.long_press_ms <= LONG_PRESS_RST;
      regs.active_low    <= ACTIVE_LOW_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE:   regs.debounce_ms   <= cfg.data;
        REG_LONG_PRESS: regs.long_press_ms <= cfg.data;
        REG_ACTIVE_LOW: regs.active_low    <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/bdpc_state.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_state
// Per-button state memory with registered read, valid bits and a bypass
// for a read issued in the same cycle as a write to the same button.
// ----------------------------------------------------------------------------
module bdpc_state import bdpc_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [BTN_W-1:0] rd_idx,
  output entry_t           rd_entry,
  input  logic             wr_en,
  input  logic [BTN_W-1:0] wr_idx,
  input  entry_t           wr_entry
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  entry_t               mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vbits;
  entry_t               mem_q;
  logic                 vld_q;
  logic                 fwd_hit;
  entry_t               fwd_entry;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  assign rd_addr = AW'(rd_idx);
  assign wr_addr = AW'(wr_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      fwd_entry <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits   <= '0;
      vld_q   <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vbits[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q   <= vbits[rd_addr];
        // The write in this cycle is not yet visible to the read.
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // An entry never written reads as the reset state: released, times zero.
  always_comb begin
    if (fwd_hit) begin
      rd_entry = fwd_entry;
    end else if (vld_q) begin
      rd_entry = mem_q;
    end else begin
      rd_entry = '0;
    end
  end

endmodule

@@ rtl/bdpc_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_update
// Debounce decision and press classification for one sample.
// ----------------------------------------------------------------------------
module bdpc_update import bdpc_pkg::*; (
  input  cfg_t              regs,
  input  logic              raw_level,
  input  logic [TIME_W-1:0] time_ms,
  input  entry_t            cur,
  output entry_t            nxt,
  output event_t            evt
);

  logic              pressed;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] held;
  logic [DUR_W-1:0]  held_sat;
  logic              change;
  logic              short_evt;
  logic              long_evt;

  always_comb begin
    pressed      = regs.active_low ? ~raw_level : raw_level;
    since_change = time_ms - cur.last_change;
    held         = time_ms - cur.press_start;
    held_sat     = (held[TIME_W-1:DUR_W] != '0) ? DUR_MAX : held[DUR_W-1:0];
    change       = (pressed != cur.level) &&
                   (since_change >= {{(TIME_W-DUR_W){1'b0}}, regs.debounce_ms});

    nxt       = cur;
    short_evt = 1'b0;
    if (change) begin
      nxt.level       = pressed;
      nxt.last_change = time_ms;
      if (pressed) begin
        nxt.press_start = time_ms;
        nxt.long_sent   = 1'b0;
      end else begin
        short_evt = !cur.long_sent;
      end
    end

    // A fresh press has zero held time, so the threshold test sees zero.
    long_evt = nxt.level && !nxt.long_sent &&
               (((change && pressed) ? '0 : held) >=
                {{(TIME_W-DUR_W){1'b0}}, regs.long_press_ms});
    if (long_evt) begin
      nxt.long_sent = 1'b1;
    end

    evt.valid    = short_evt || long_evt;
    evt.kind     = long_evt ? KIND_LONG : KIND_SHORT;
    evt.duration = long_evt ? regs.long_press_ms : held_sat;
  end

endmodule

@@ rtl/button_debounce_press_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a bank of buttons and reports short and long presses.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while the event output is not
// stalled, any button in any order. A sample is held in stage s1 and its
// event beat in the output register. The rate is set by one read-modify-write
// of the per-button state memory per cycle; a sample of the same button in
// back-to-back cycles is served through a bypass of the previous write.
// Samples whose button index lies beyond the bank are dropped without effect.
// State starts released with zero times after reset, with no clearing pass.
module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic clk,
  input  logic rst,
  bdpc_sample_if.sink   samples,
  bdpc_event_if.source  events,
  bdpc_cfg_if.sink      cfg
);

  cfg_t              regs;
  logic              advance;
  logic              accept;
  logic              s1_valid;
  logic              s1_in_range;
  logic [BTN_W-1:0]  s1_button;
  logic              s1_raw;
  logic [TIME_W-1:0] s1_time;
  entry_t            cur_entry;
  entry_t            nxt_entry;
  event_t            evt;
  logic              wr_en;
  logic              out_valid;

  assign advance       = !out_valid || events.ready;
  assign samples.ready = advance || !s1_valid;
  assign accept        = samples.valid && samples.ready;
  assign wr_en         = s1_valid && s1_in_range && advance;

  bdpc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bdpc_state #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_idx   (samples.button_index),
    .rd_entry (cur_entry),
    .wr_en    (wr_en),
    .wr_idx   (s1_button),
    .wr_entry (nxt_entry)
  );

  bdpc_update u_update (
    .regs      (regs),
    .raw_level (s1_raw),
    .time_ms   (s1_time),
    .cur       (cur_entry),
    .nxt       (nxt_entry),
    .evt       (evt)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_button   <= samples.button_index;
      s1_raw      <= samples.raw_level;
      s1_time     <= samples.time_ms;
      s1_in_range <= (int'(samples.button_index) < NUM_BUTTONS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && s1_in_range && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      events.event_button <= s1_button;
      events.event_kind   <= evt.kind;
      events.duration_ms  <= evt.duration;
    end
  end

  assign events.valid = out_valid;

endmodule
